>>> rtl/mma_pkg.sv
// shared types, constants and helper functions for the matrix multiply-accumulate block
package mma_pkg;

    // largest matrix dimension held in the stores
    localparam int MAX_DIM = 8;
    localparam int CELLS   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int CNT_W   = $clog2(MAX_DIM + 1);

    // fixed field widths
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 4;
    localparam int VAL_W   = 48;
    localparam int AB_W    = 16;
    localparam int PROD_W  = 2 * AB_W;
    localparam int CSEL_W  = 2;

    typedef enum logic [1:0] {
        MODE_LOAD_A = 2'd0,
        MODE_LOAD_B = 2'd1,
        MODE_LOAD_C = 2'd2,
        MODE_RUN    = 2'd3
    } t_mode;

    typedef enum logic [CSEL_W-1:0] {
        REG_ROWS_M  = 2'd0,
        REG_COLS_N  = 2'd1,
        REG_INNER_K = 2'd2,
        REG_NONE    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_mode                    mode;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [VAL_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
        logic signed [VAL_W-1:0]  out_value;
        logic                     last;
    } t_out_item;

    // active matrix sizes
    typedef struct packed {
        logic [CNT_W-1:0] rows;
        logic [CNT_W-1:0] cols;
        logic [CNT_W-1:0] inner;
    } t_dims;

    // read request from the sequencer to the three stores
    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
        logic [ADDR_W-1:0] c_addr;
    } t_rd_req;

    // write-back of one finished C element
    typedef struct packed {
        logic                    we;
        logic [ADDR_W-1:0]       addr;
        logic signed [VAL_W-1:0] data;
    } t_c_wr;

    // row-major store address of one element
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        int a;
        a = int'(r) * MAX_DIM + int'(c);
        return ADDR_W'(a);
    endfunction

    // limit a register write to 1 .. MAX_DIM
    function automatic logic [CNT_W-1:0] fit_dim(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] res;
        if (v == '0) begin
            res = CNT_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            res = CNT_W'(MAX_DIM);
        end else begin
            res = CNT_W'(v);
        end
        return res;
    endfunction

    // clamp a load value into the Q8.8 range; it is taken at Q8.8 scale, not rescaled from Q16.16
    function automatic logic signed [AB_W-1:0] clamp_q88(input logic signed [VAL_W-1:0] v);
        logic signed [AB_W-1:0] res;
        if (v > VAL_W'(32767)) begin
            res = 16'sh7fff;
        end else if (v < -VAL_W'(32768)) begin
            res = 16'sh8000;
        end else begin
            res = v[AB_W-1:0];
        end
        return res;
    endfunction

    // saturate a grown sum back to 48 bits
    function automatic logic signed [VAL_W-1:0] sat48(input logic signed [VAL_W:0] s);
        logic signed [VAL_W-1:0] res;
        if (s[VAL_W] != s[VAL_W-1]) begin
            res = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            res = s[VAL_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/mma_ram.sv
// generic simple dual-port memory with registered read
module mma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/mma_seq.sv
// run sequencer: walks i, j, k over the stores, multiplies, accumulates and emits C
module mma_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  mma_pkg::t_dims                  i_dims,
    output mma_pkg::t_rd_req                o_rd,
    input  logic signed [mma_pkg::AB_W-1:0] i_a_rd,
    input  logic signed [mma_pkg::AB_W-1:0] i_b_rd,
    input  logic signed [mma_pkg::VAL_W-1:0] i_c_rd,
    output mma_pkg::t_c_wr                  o_cwr,
    output logic                            o_busy,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output mma_pkg::t_out_item              o_out_data
);
    import mma_pkg::*;

    // issue counters
    logic             r_run;
    logic [DIM_W-1:0] r_i, r_j, r_k;

    // stage 1: store read data
    logic             r_d1_vld, r_d1_first, r_d1_last, r_d1_end;
    logic [DIM_W-1:0] r_d1_i, r_d1_j;

    // stage 2: product
    logic                     r_d2_vld, r_d2_first, r_d2_last, r_d2_end;
    logic [DIM_W-1:0]         r_d2_i, r_d2_j;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [VAL_W-1:0]  r_chold;
    logic signed [VAL_W-1:0]  r_acc;

    // output register
    logic      r_out_vld;
    t_out_item r_out;

    logic                    adv, issue, emit;
    logic                    k_end, j_end, i_end;
    logic [DIM_W-1:0]        k_lim, j_lim, i_lim;
    logic signed [VAL_W-1:0] acc_base, acc_new;
    logic signed [VAL_W:0]   acc_sum;

    // whole pipeline holds only when a finished element cannot leave
    assign adv   = !(r_d2_vld && r_d2_last && r_out_vld && !i_out_ready);
    assign issue = r_run && adv;
    assign emit  = adv && r_d2_vld && r_d2_last;

    assign k_lim = DIM_W'(i_dims.inner - CNT_W'(1));
    assign j_lim = DIM_W'(i_dims.cols - CNT_W'(1));
    assign i_lim = DIM_W'(i_dims.rows - CNT_W'(1));
    assign k_end = (r_k == k_lim);
    assign j_end = (r_j == j_lim);
    assign i_end = (r_i == i_lim);

    // read addresses for the current step
    always_comb begin
        o_rd.re     = issue;
        o_rd.a_addr = cell_addr(IDX_W'(r_i), IDX_W'(r_k));
        o_rd.b_addr = cell_addr(IDX_W'(r_k), IDX_W'(r_j));
        o_rd.c_addr = cell_addr(IDX_W'(r_i), IDX_W'(r_j));
    end

    // loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_i   <= '0;
            r_j   <= '0;
            r_k   <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_i   <= '0;
            r_j   <= '0;
            r_k   <= '0;
        end else if (issue) begin
            if (!k_end) begin
                r_k <= r_k + DIM_W'(1);
            end else begin
                r_k <= '0;
                if (!j_end) begin
                    r_j <= r_j + DIM_W'(1);
                end else begin
                    r_j <= '0;
                    if (!i_end) begin
                        r_i <= r_i + DIM_W'(1);
                    end else begin
                        r_run <= 1'b0;
                    end
                end
            end
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_vld <= 1'b0;
            r_d2_vld <= 1'b0;
        end else if (adv) begin
            r_d1_vld <= issue;
            r_d2_vld <= r_d1_vld;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d1_first <= (r_k == '0);
            r_d1_last  <= k_end;
            r_d1_end   <= k_end && j_end && i_end;
            r_d1_i     <= r_i;
            r_d1_j     <= r_j;
            r_d2_first <= r_d1_first;
            r_d2_last  <= r_d1_last;
            r_d2_end   <= r_d1_end;
            r_d2_i     <= r_d1_i;
            r_d2_j     <= r_d1_j;
            r_prod     <= i_a_rd * i_b_rd;
            if (r_d1_vld && r_d1_first) begin
                r_chold <= i_c_rd;
            end
            if (r_d2_vld) begin
                r_acc <= acc_new;
            end
        end
    end

    // saturating accumulate
    assign acc_base = r_d2_first ? r_chold : r_acc;
    assign acc_sum  = (VAL_W + 1)'(acc_base) + (VAL_W + 1)'(r_prod);
    assign acc_new  = sat48(acc_sum);

    // write back the finished element
    always_comb begin
        o_cwr.we   = emit;
        o_cwr.addr = cell_addr(IDX_W'(r_d2_i), IDX_W'(r_d2_j));
        o_cwr.data = acc_new;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.out_row   <= IDX_W'(r_d2_i);
            r_out.out_col   <= IDX_W'(r_d2_j);
            r_out.out_value <= acc_new;
            r_out.last      <= r_d2_end;
        end
    end

    assign o_busy      = r_run || r_d1_vld || r_d2_vld;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // a run only starts on an empty pipeline
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !o_busy)
        else $error("run started while busy");

    // stage 1 moves into stage 2 whenever the pipeline advances
    a_d1_to_d2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d1_vld && adv) |=> r_d2_vld)
        else $error("step lost between stages");

    // the final element only leaves the pipeline once issuing has finished
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_d2_end) |-> !r_run)
        else $error("last element while still issuing");

    // a blocked element keeps the accumulator
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_acc))
        else $error("accumulator moved during stall");

endmodule

>>> rtl/matrix_multiply_accumulate.sv
// top level of the matrix multiply-accumulate block: configuration, load decode, stores
//
// Computes C += A * B on fixed-point matrices of up to MAX_DIM x MAX_DIM.
// Input channel (i_in_valid / o_in_ready / i_in_data): each transaction is a load
// of one A, B (Q8.8, clamped) or C (Q32.16) element, or a run. A load gives no
// result; loads outside the stores are dropped.
// A run emits every C element of rows_m x cols_n in row-major order on the output
// channel (o_out_valid / i_out_ready / o_out_data), the final one with last set,
// and writes each back into the C store.
// A run issues one multiply-accumulate per cycle through the store read ports
// while the output does not stall. Each step passes the store read registers and
// the product register; finished elements are registered at the output.
// o_in_ready is low while a run is in progress; a load or run may be accepted
// while the last result still waits in the output register.
// When the receiver stalls, the whole multiply pipeline holds once the next
// finished element has nowhere to go, and resumes without loss.
// Configuration (i_cfg_we / i_cfg_addr / i_cfg_wdata) is to be written by the user
// only while idle; the block itself does not enforce this. Values are held within
// 1 .. MAX_DIM. Reset (i_rst_n low, synchronous) sets all sizes to MAX_DIM and
// empties the pipeline; store contents are undefined until loaded.
module matrix_multiply_accumulate (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mma_pkg::CSEL_W-1:0]  i_cfg_addr,
    input  logic [mma_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  mma_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output mma_pkg::t_out_item          o_out_data
);
    import mma_pkg::*;

    logic [CNT_W-1:0] r_rows, r_cols, r_inner;
    t_dims            dims;
    t_rd_req          rd;
    t_c_wr            seq_cwr;
    logic             busy, accept, in_range, start;
    logic             a_we, b_we, c_we;
    logic [ADDR_W-1:0]       ld_addr, c_waddr;
    logic signed [AB_W-1:0]  ld_ab;
    logic signed [VAL_W-1:0] c_wdata;
    logic signed [AB_W-1:0]  a_rd, b_rd;
    logic signed [VAL_W-1:0] c_rd;

    // size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= CNT_W'(MAX_DIM);
            r_cols  <= CNT_W'(MAX_DIM);
            r_inner <= CNT_W'(MAX_DIM);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_ROWS_M:  r_rows  <= fit_dim(i_cfg_wdata);
                REG_COLS_N:  r_cols  <= fit_dim(i_cfg_wdata);
                REG_INNER_K: r_inner <= fit_dim(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    assign dims.rows  = r_rows;
    assign dims.cols  = r_cols;
    assign dims.inner = r_inner;

    // input transaction decode
    assign o_in_ready = !busy;
    assign accept     = i_in_valid && o_in_ready;
    assign in_range   = (32'(i_in_data.row) < MAX_DIM) && (32'(i_in_data.col) < MAX_DIM);
    assign start      = accept && (i_in_data.mode == MODE_RUN);
    assign a_we       = accept && in_range && (i_in_data.mode == MODE_LOAD_A);
    assign b_we       = accept && in_range && (i_in_data.mode == MODE_LOAD_B);
    assign ld_addr    = cell_addr(i_in_data.row, i_in_data.col);
    assign ld_ab      = clamp_q88(i_in_data.value);

    // C store write: run write-back or a load, never both at once
    assign c_we    = seq_cwr.we || (accept && in_range && (i_in_data.mode == MODE_LOAD_C));
    assign c_waddr = seq_cwr.we ? seq_cwr.addr : ld_addr;
    assign c_wdata = seq_cwr.we ? seq_cwr.data : i_in_data.value;

    mma_ram #(.WIDTH(AB_W), .DEPTH(CELLS)) u_a_store (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (ld_addr),
        .i_wdata (ld_ab),
        .i_re    (rd.re),
        .i_raddr (rd.a_addr),
        .o_rdata (a_rd)
    );

    mma_ram #(.WIDTH(AB_W), .DEPTH(CELLS)) u_b_store (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (ld_addr),
        .i_wdata (ld_ab),
        .i_re    (rd.re),
        .i_raddr (rd.b_addr),
        .o_rdata (b_rd)
    );

    mma_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_c_store (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (rd.re),
        .i_raddr (rd.c_addr),
        .o_rdata (c_rd)
    );

    mma_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_dims      (dims),
        .o_rd        (rd),
        .i_a_rd      (a_rd),
        .i_b_rd      (b_rd),
        .i_c_rd      (c_rd),
        .o_cwr       (seq_cwr),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
